FILE: design/lpr_pkg.sv
package lpr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IFACE_COUNT   = 4;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [4:0] MAX_PREFIX_BYTES = 5'd16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ROUTE   = 3'd0,
    ST_MCAST   = 3'd1,
    ST_LLOCAL  = 3'd2,
    ST_NOROUTE = 3'd3,
    ST_BADIF   = 3'd4,
    ST_WRITTEN = 3'd5
  } status_t;

  typedef struct packed {
    logic        op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [4:0]  entry_prefix_bytes;
    logic [1:0]  entry_iface;
    logic        entry_onlink;
    logic [63:0] entry_hop_hi;
    logic [63:0] entry_hop_lo;
    logic [2:0]  given_iface;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  out_iface;
    logic [63:0] hop_hi;
    logic [63:0] hop_lo;
    logic [3:0]  hit_index;
  } rsp_t;

  // Per-entry control word: valid, length in bytes, interface, on-link.
  typedef struct packed {
    logic       onlink;
    logic [1:0] iface;
    logic [4:0] len;
    logic       valid;
  } meta_t;

  // Best match found so far during a scan.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [1:0]       iface;
    logic             onlink;
    logic [127:0]     hop;
  } best_t;

endpackage

FILE: design/lpr_table.sv
module lpr_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [lpr_pkg::IDX_W-1:0] wr_addr,
  input  lpr_pkg::meta_t            wr_meta,
  input  logic [127:0]              wr_prefix,
  input  logic [127:0]              wr_hop,
  input  logic [lpr_pkg::IDX_W-1:0] rd_addr,
  output lpr_pkg::meta_t            rd_meta,
  output logic [127:0]              rd_prefix,
  output logic [127:0]              rd_hop
);
  import lpr_pkg::*;

  meta_t        meta [TABLE_ENTRIES];
  logic [127:0] prefix_mem [TABLE_ENTRIES];
  logic [127:0] hop_mem [TABLE_ENTRIES];

  // Control words reset to free; prefixes and hops only matter once written.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        meta[i] <= '0;
      end
    end else if (wr_en) begin
      meta[wr_addr] <= wr_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[wr_addr] <= wr_prefix;
      hop_mem[wr_addr]    <= wr_hop;
    end
  end

  always_ff @(posedge clk) begin
    rd_meta   <= meta[rd_addr];
    rd_prefix <= prefix_mem[rd_addr];
    rd_hop    <= hop_mem[rd_addr];
  end

endmodule

FILE: design/lpr_match.sv
module lpr_match (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      en,
  input  logic [lpr_pkg::IDX_W-1:0] idx,
  input  logic [127:0]              dest,
  input  lpr_pkg::meta_t            meta,
  input  logic [127:0]              prefix,
  input  logic [127:0]              hop,
  output lpr_pkg::best_t            best
);
  import lpr_pkg::*;

  logic [127:0] mask;
  logic [4:0]   best_len;
  logic         hit;
  logic         take;

  // Leading bytes covered by the prefix length, most significant byte first.
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      mask[127 - 8 * b -: 8] = (5'(b) < meta.len) ? 8'hff : 8'h00;
    end
  end

  assign hit  = meta.valid && (((dest ^ prefix) & mask) == '0);
  // A strictly longer match replaces the best, so ties keep the lower index.
  assign take = en && hit && (!best.found || (meta.len > best_len));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (take) begin
      best.found  <= 1'b1;
      best.idx    <= idx;
      best.iface  <= meta.iface;
      best.onlink <= meta.onlink;
      best.hop    <= hop;
      best_len    <= meta.len;
    end
  end

endmodule

FILE: design/ipv6_longest_prefix_route.sv
// Channel   Payload           Handshake
// req       lpr_pkg::req_t    req_valid / req_stall   (write entry or lookup)
// rsp       lpr_pkg::rsp_t    rsp_valid / rsp_stall   (one result per request)
//
// A write or a table bypass goes from accept to the finish state. A table
// lookup walks the scan, drain and finish states: one entry is read from the
// table memory and compared by the shared match unit each cycle, the read and
// the compare each registered. Requests are taken only while the sequencer
// is idle. The table comes out of reset with every entry free. A stalled
// result holds in the output register and the sequencer waits to load it.
module ipv6_longest_prefix_route (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lpr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lpr_pkg::rsp_t rsp
);
  import lpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [127:0]     dest;
  logic             from_table;
  rsp_t             res;
  rsp_t             fin_rsp;
  rsp_t             acc_rsp;
  logic             load_rsp;

  logic             accept;
  logic             is_mcast;
  logic             is_llocal;
  logic             iface_ok;
  logic [IDX_W+3:0] wr_index_ext;
  logic             wr_en;
  meta_t            wr_meta;
  logic [4:0]       wr_len;

  meta_t            rd_meta;
  logic [127:0]     rd_prefix;
  logic [127:0]     rd_hop;
  best_t            best;
  logic [IDX_W+3:0] hit_ext;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign is_mcast  = (req.addr_hi[63:56] == 8'hff);
  assign is_llocal = (req.addr_hi[63:54] == 10'h3fa);
  assign iface_ok  = ({1'b0, req.given_iface} < 4'(IFACE_COUNT));

  // Writes beyond the table are dropped but still answered.
  assign wr_index_ext = (IDX_W + 4)'(req.entry_index);
  assign wr_en  = accept && (req.op == OP_WRITE) &&
                  (wr_index_ext < (IDX_W + 4)'(TABLE_ENTRIES));
  assign wr_len = (req.entry_prefix_bytes > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES
                                                              : req.entry_prefix_bytes;

  always_comb begin
    wr_meta.onlink = req.entry_onlink;
    wr_meta.iface  = req.entry_iface;
    wr_meta.len    = wr_len;
    wr_meta.valid  = req.entry_valid;
  end

  lpr_table u_table (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_index_ext[IDX_W-1:0]),
    .wr_meta   (wr_meta),
    .wr_prefix ({req.addr_hi, req.addr_lo}),
    .wr_hop    ({req.entry_hop_hi, req.entry_hop_lo}),
    .rd_addr   (cnt),
    .rd_meta   (rd_meta),
    .rd_prefix (rd_prefix),
    .rd_hop    (rd_hop)
  );

  lpr_match u_match (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == S_IDLE),
    .en     (cmp_valid),
    .idx    (cmp_idx),
    .dest   (dest),
    .meta   (rd_meta),
    .prefix (rd_prefix),
    .hop    (rd_hop),
    .best   (best)
  );

  assign hit_ext = (IDX_W + 4)'(best.idx);

  // Result of a write or a bypass, known already at accept.
  always_comb begin
    acc_rsp = '0;
    if (req.op == OP_WRITE) begin
      acc_rsp.status = ST_WRITTEN;
    end else if (is_mcast || is_llocal) begin
      acc_rsp.out_iface = req.given_iface;
      if (iface_ok) begin
        acc_rsp.status = is_mcast ? ST_MCAST : ST_LLOCAL;
        acc_rsp.hop_hi = req.addr_hi;
        acc_rsp.hop_lo = req.addr_lo;
      end else begin
        acc_rsp.status = ST_BADIF;
      end
    end
  end

  always_comb begin
    fin_rsp = res;
    if (from_table) begin
      if (best.found) begin
        fin_rsp.status    = ST_ROUTE;
        fin_rsp.out_iface = {1'b0, best.iface};
        {fin_rsp.hop_hi, fin_rsp.hop_lo} = best.onlink ? dest : best.hop;
        fin_rsp.hit_index = hit_ext[3:0];
      end else begin
        fin_rsp = '0;
        fin_rsp.status = ST_NOROUTE;
      end
    end
  end

  assign load_rsp = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      cmp_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
      from_table <= 1'b0;
    end else begin
      cmp_valid <= (state == S_SCAN);
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.op == OP_WRITE) begin
              from_table <= 1'b0;
              state      <= S_FINISH;
            end else if (is_mcast || is_llocal) begin
              from_table <= 1'b0;
              state      <= S_FINISH;
            end else begin
              from_table <= 1'b1;
              cnt        <= '0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (load_rsp) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request context and the output holding register.
  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    if (accept) begin
      dest <= {req.addr_hi, req.addr_lo};
      res  <= acc_rsp;
    end
    if (load_rsp) begin
      rsp <= fin_rsp;
    end
  end

endmodule
